@@ sv/circular_deque_core_assert.svh @@
// Assertion macros for the checker file of the deque block.
`ifndef CIRCULAR_DEQUE_CORE_ASSERT_SVH
`define CIRCULAR_DEQUE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CDQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

@@ sv/cdq_pkg.sv @@
package cdq_pkg;

    localparam int CAPACITY = 15;
    localparam int SLOTS    = CAPACITY + 1;
    localparam int IDX_W    = (SLOTS > 2) ? $clog2(SLOTS) : 1;
    localparam int WORD_W   = 32;

    typedef enum logic [1:0] {
        FUNC_PUSH_FRONT = 2'd0,
        FUNC_PUSH_REAR  = 2'd1,
        FUNC_POP_FRONT  = 2'd2,
        FUNC_POP_REAR   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } status_t;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        func_t              func;
        logic signed [31:0] push_value;
    } item_t;

    typedef struct packed {
        logic signed [31:0] pop_value;
        status_t            status;
        logic               is_empty;
        logic               is_full;
    } result_t;

    // Memory request from the index logic.
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        idx_t              addr;
        logic [WORD_W-1:0] wdata;
    } mem_req_t;

    // Outcome of one operation, ahead of the read data.
    typedef struct packed {
        logic    from_mem;
        status_t status;
        logic    is_empty;
        logic    is_full;
    } outcome_t;

    function automatic idx_t next_slot(input idx_t i);
        return (i == idx_t'(SLOTS - 1)) ? '0 : idx_t'(i + idx_t'(1));
    endfunction

    function automatic idx_t prev_slot(input idx_t i);
        return (i == '0) ? idx_t'(SLOTS - 1) : idx_t'(i - idx_t'(1));
    endfunction

endpackage

@@ sv/cdq_ram.sv @@
module cdq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int ADDR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/cdq_index.sv @@
module cdq_index (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  cdq_pkg::item_t    item,
    output cdq_pkg::mem_req_t mem_req,
    output cdq_pkg::outcome_t outcome
);

    cdq_pkg::idx_t front_reg, front_next;
    cdq_pkg::idx_t rear_reg, rear_next;
    cdq_pkg::idx_t step_idx;
    logic          full_now, empty_now;

    assign empty_now = (front_reg == rear_reg);
    assign full_now  = (front_reg == cdq_pkg::next_slot(rear_reg));

    always_comb
    begin
        front_next       = front_reg;
        rear_next        = rear_reg;
        step_idx         = '0;
        mem_req.wr_en    = 1'b0;
        mem_req.rd_en    = 1'b0;
        mem_req.addr     = front_reg;
        mem_req.wdata    = item.push_value;
        outcome.from_mem = 1'b0;
        outcome.status   = cdq_pkg::STATUS_OK;
        case (item.func)
            cdq_pkg::FUNC_PUSH_FRONT:
            begin
                if (full_now)
                begin
                    outcome.status = cdq_pkg::STATUS_OVERFLOW;
                end
                else
                begin
                    mem_req.wr_en = fire;
                    mem_req.addr  = front_reg;
                    front_next    = cdq_pkg::prev_slot(front_reg);
                end
            end
            cdq_pkg::FUNC_PUSH_REAR:
            begin
                if (full_now)
                begin
                    outcome.status = cdq_pkg::STATUS_OVERFLOW;
                end
                else
                begin
                    step_idx      = cdq_pkg::next_slot(rear_reg);
                    mem_req.wr_en = fire;
                    mem_req.addr  = step_idx;
                    rear_next     = step_idx;
                end
            end
            cdq_pkg::FUNC_POP_FRONT:
            begin
                if (empty_now)
                begin
                    outcome.status = cdq_pkg::STATUS_UNDERFLOW;
                end
                else
                begin
                    step_idx         = cdq_pkg::next_slot(front_reg);
                    mem_req.rd_en    = fire;
                    mem_req.addr     = step_idx;
                    outcome.from_mem = 1'b1;
                    front_next       = step_idx;
                    if (step_idx == rear_reg)
                    begin
                        front_next = '0;
                        rear_next  = '0;
                    end
                end
            end
            cdq_pkg::FUNC_POP_REAR:
            begin
                if (empty_now)
                begin
                    outcome.status = cdq_pkg::STATUS_UNDERFLOW;
                end
                else
                begin
                    step_idx         = cdq_pkg::prev_slot(rear_reg);
                    mem_req.rd_en    = fire;
                    mem_req.addr     = rear_reg;
                    outcome.from_mem = 1'b1;
                    rear_next        = step_idx;
                    if (step_idx == front_reg)
                    begin
                        front_next = '0;
                        rear_next  = '0;
                    end
                end
            end
            default:
            begin
                outcome.status = cdq_pkg::STATUS_OK;
            end
        endcase
        outcome.is_empty = (front_next == rear_next);
        outcome.is_full  = (front_next == cdq_pkg::next_slot(rear_next));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
        end
        else if (fire)
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
        end
    end

endmodule

@@ sv/circular_deque_core.sv @@
// Double-ended queue of signed 32-bit words, up to cdq_pkg::CAPACITY of them,
// kept in a ring of CAPACITY+1 slots in one synchronous memory.
// Input channel (item_valid / item_stall / item): each beat asks for one of
// push front, push rear, pop front, pop rear. Output channel (result_valid /
// result_stall / result): exactly one beat per input beat, in order, carrying
// the popped word (-1 on a push or underflow), the status code and the empty
// and full flags after the operation.
// Each result passes the pending stage, then the output register.
// Throughput: one beat per cycle while the output drains; the memory is
// touched once per operation at the acceptance edge (write for a push,
// read for a pop), and its read register takes the data at that edge.
// Reset empties the deque (both ring indices to zero) and drops any result
// in flight; memory contents are left as they are.
// When the receiver stalls, the output register holds its beat, one more
// result waits in the pending stage, and then item_stall rises until the
// output frees up. Nothing is ever dropped.
module circular_deque_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  cdq_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output cdq_pkg::result_t result
);

    cdq_pkg::mem_req_t mem_req;
    cdq_pkg::outcome_t outcome;
    logic [cdq_pkg::WORD_W-1:0] mem_rdata;

    // Pending stage: the outcome of the last accepted operation, waiting for
    // read data and a free output register.
    logic              pend_valid_reg;
    cdq_pkg::outcome_t pend_reg;

    logic              out_valid_reg;
    cdq_pkg::result_t  out_reg, out_next;

    logic out_free;
    logic pend_move;
    logic fire;

    // Output register can take a beat when empty or being drained this cycle.
    assign out_free   = !out_valid_reg || !result_stall;
    assign pend_move  = pend_valid_reg && out_free;
    // Hold the input while the pending stage is blocked.
    assign item_stall = pend_valid_reg && !pend_move;
    assign fire       = item_valid && !item_stall;

    cdq_index u_index (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .item    (item),
        .mem_req (mem_req),
        .outcome (outcome)
    );

    // The memory is only accessed on an accepted beat, so its read register
    // holds steady while the pending stage waits.
    cdq_ram #(
        .DEPTH (cdq_pkg::SLOTS),
        .WIDTH (cdq_pkg::WORD_W)
    ) u_ram (
        .clk   (clk),
        .wr_en (mem_req.wr_en),
        .rd_en (mem_req.rd_en),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (mem_rdata)
    );

    // Assemble the result beat; use read data only for a successful pop.
    always_comb
    begin
        out_next.pop_value = pend_reg.from_mem ? $signed(mem_rdata) : -32'sd1;
        out_next.status    = pend_reg.status;
        out_next.is_empty  = pend_reg.is_empty;
        out_next.is_full   = pend_reg.is_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (pend_move)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (out_free)
            begin
                out_valid_reg <= pend_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            pend_reg <= outcome;
        end
        if (pend_move)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

@@ sv/cdq_checker.sv @@
`include "circular_deque_core_assert.svh"

module cdq_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input cdq_pkg::item_t   item,
    input logic             result_valid,
    input logic             result_stall,
    input cdq_pkg::result_t result
);

    logic res_fail;
    logic res_under;
    logic res_over;
    logic res_neg_one;

    assign res_fail    = result_valid && (result.status != cdq_pkg::STATUS_OK);
    assign res_under   = result_valid && (result.status == cdq_pkg::STATUS_UNDERFLOW);
    assign res_over    = result_valid && (result.status == cdq_pkg::STATUS_OVERFLOW);
    assign res_neg_one = (result.pop_value == -32'sd1);

    // A held input beat keeps its payload.
    `CDQ_ASSERT_NEXT(a_item_hold, clk, rst_n, item_valid && item_stall, item_valid && $stable(item))

    // A held result beat keeps its payload.
    `CDQ_ASSERT_NEXT(a_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result))

    // Any failed operation carries -1.
    `CDQ_ASSERT_NOW(a_fail_neg, clk, rst_n, res_fail, res_neg_one)

    // Underflow only on an empty deque, overflow only on a full one.
    `CDQ_ASSERT_NOW(a_under_empty, clk, rst_n, res_under, result.is_empty)
    `CDQ_ASSERT_NOW(a_over_full, clk, rst_n, res_over, result.is_full)

endmodule

bind circular_deque_core cdq_checker u_cdq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

@@ test/tb_circular_deque_core.sv @@
// Testbench for circular_deque_core.
// Drive push/pop beats through the valid/stall input channel and track the
// deque in a behavioral ring kept here: every accepted beat advances that ring
// and queues the result it must produce. Each result beat taken at the output
// is compared field by field against the oldest queued result.
// Traffic runs in three idle regimes (sender 35% / receiver 69%, then 69% /
// 35%, then no idling at all) and includes one long receiver hold-off while
// the sender keeps offering beats, so the block fills up and stalls its input.
module tb_circular_deque_core;

    localparam int CLK_PERIOD  = 12;
    localparam int RESET_TICKS = 7;
    localparam int MAX_REPORTS = 10;
    localparam int TAIL_TICKS  = 6;    // output pipeline drain plus margin
    localparam int LIMIT_TICKS = 300000;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_stall;
    cdq_pkg::item_t   item         = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    cdq_pkg::result_t result;

    // Idle rates in percent, set per traffic regime.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Long receiver hold-off, raised and lowered by its own timing process.
    logic rx_hold = 1'b0;

    // Behavioral copy of the deque: ring words, the free slot before the
    // first word, and the slot of the last word.
    logic [cdq_pkg::WORD_W-1:0] ring_words [cdq_pkg::SLOTS];
    cdq_pkg::idx_t              head_gap  = '0;
    cdq_pkg::idx_t              tail_slot = '0;

    cdq_pkg::result_t pending_results [$];
    int               mismatch_count = 0;

    circular_deque_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Move one slot around the ring, forward or backward.
    function automatic cdq_pkg::idx_t ring_step(input cdq_pkg::idx_t i, input bit fwd);
        if (fwd)
            return (i == cdq_pkg::idx_t'(cdq_pkg::SLOTS - 1)) ?
                   cdq_pkg::idx_t'(0) : cdq_pkg::idx_t'(i + cdq_pkg::idx_t'(1));
        return (i == cdq_pkg::idx_t'(0)) ?
               cdq_pkg::idx_t'(cdq_pkg::SLOTS - 1) : cdq_pkg::idx_t'(i - cdq_pkg::idx_t'(1));
    endfunction

    // Apply one operation to the behavioral ring and return the result beat
    // it must produce.
    function automatic cdq_pkg::result_t apply_deque_op(input cdq_pkg::item_t beat);
        cdq_pkg::result_t out;
        logic             was_empty;
        logic             was_full;
        was_empty     = (head_gap == tail_slot);
        was_full      = (head_gap == ring_step(tail_slot, 1'b1));
        out.pop_value = '1;
        out.status    = cdq_pkg::STATUS_OK;
        case (beat.func)
            cdq_pkg::FUNC_PUSH_FRONT:
            begin
                if (was_full)
                    out.status = cdq_pkg::STATUS_OVERFLOW;
                else
                begin
                    ring_words[head_gap] = beat.push_value;
                    head_gap = ring_step(head_gap, 1'b0);
                end
            end
            cdq_pkg::FUNC_PUSH_REAR:
            begin
                if (was_full)
                    out.status = cdq_pkg::STATUS_OVERFLOW;
                else
                begin
                    tail_slot = ring_step(tail_slot, 1'b1);
                    ring_words[tail_slot] = beat.push_value;
                end
            end
            cdq_pkg::FUNC_POP_FRONT:
            begin
                if (was_empty)
                    out.status = cdq_pkg::STATUS_UNDERFLOW;
                else
                begin
                    head_gap = ring_step(head_gap, 1'b1);
                    out.pop_value = ring_words[head_gap];
                end
            end
            default:
            begin
                if (was_empty)
                    out.status = cdq_pkg::STATUS_UNDERFLOW;
                else
                begin
                    out.pop_value = ring_words[tail_slot];
                    tail_slot = ring_step(tail_slot, 1'b0);
                end
            end
        endcase
        // A pop that drains the ring parks both indices at slot zero.
        if (head_gap == tail_slot)
        begin
            head_gap  = '0;
            tail_slot = '0;
        end
        out.is_empty = (head_gap == tail_slot);
        out.is_full  = (head_gap == ring_step(tail_slot, 1'b1));
        return out;
    endfunction

    // Pick a word, favoring the sign and all-ones/all-zeros extremes.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '1;
            3: return '0;
            default: return $urandom();
        endcase
    endfunction

    // Pick an operation: pushes come with probability push_pct percent.
    function automatic cdq_pkg::func_t pick_op(input int push_pct);
        if ($urandom_range(99) < push_pct)
            return $urandom_range(1) ? cdq_pkg::FUNC_PUSH_REAR : cdq_pkg::FUNC_PUSH_FRONT;
        return $urandom_range(1) ? cdq_pkg::FUNC_POP_REAR : cdq_pkg::FUNC_POP_FRONT;
    endfunction

    // Offer one beat and hold it until the block takes it. Call at a rising
    // edge; return at the edge that accepted the beat with valid still high,
    // so a back-to-back beat never lowers and raises valid in one step.
    task automatic send_item(input cdq_pkg::func_t op, input logic [31:0] word);
        cdq_pkg::item_t beat;
        beat.func       = op;
        beat.push_value = word;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= beat;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        pending_results.push_back(apply_deque_op(beat));
    endtask

    task automatic report_mismatch(input string what, input cdq_pkg::result_t want,
                                   input cdq_pkg::result_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("MISMATCH %s: expected pop=%h st=%0d e=%b f=%b, %s",
                     what, want.pop_value, want.status, want.is_empty, want.is_full,
                     $sformatf("got pop=%h st=%0d e=%b f=%b",
                               got.pop_value, got.status, got.is_empty, got.is_full));
    endtask

    task automatic check_result(input cdq_pkg::result_t got);
        cdq_pkg::result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("unexpected beat", '0, got);
            return;
        end
        want = pending_results.pop_front();
        if (got.pop_value !== want.pop_value)
            report_mismatch("pop_value", want, got);
        if (got.status !== want.status)
            report_mismatch("status", want, got);
        if (got.is_empty !== want.is_empty)
            report_mismatch("is_empty", want, got);
        if (got.is_full !== want.is_full)
            report_mismatch("is_full", want, got);
    endtask

    // Output side: take result beats, then stall at random or during a hold.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            check_result(result);
        result_stall <= rx_hold || ($urandom_range(99) < recv_idle_pct);
    end

    // Underflow on both ends, a short fill and drain, then fill to capacity
    // (wrapping the front index below slot zero), overflow on both ends, and
    // pop once from each end of the full ring.
    task automatic test_directed();
        send_item(cdq_pkg::FUNC_POP_FRONT, 32'h1234_5678);
        send_item(cdq_pkg::FUNC_POP_REAR, '1);
        send_item(cdq_pkg::FUNC_PUSH_FRONT, 32'h8000_0000);
        send_item(cdq_pkg::FUNC_PUSH_REAR, 32'h7FFF_FFFF);
        send_item(cdq_pkg::FUNC_POP_REAR, '0);
        send_item(cdq_pkg::FUNC_POP_FRONT, '0);
        for (int i = 0; i < cdq_pkg::CAPACITY; i++)
        begin
            case (i)
                0: send_item(cdq_pkg::FUNC_PUSH_FRONT, '1);
                1: send_item(cdq_pkg::FUNC_PUSH_REAR, '0);
                2: send_item(cdq_pkg::FUNC_PUSH_FRONT, 32'h5555_5555);
                3: send_item(cdq_pkg::FUNC_PUSH_REAR, 32'hAAAA_AAAA);
                default: send_item(i[0] ? cdq_pkg::FUNC_PUSH_REAR : cdq_pkg::FUNC_PUSH_FRONT,
                                   $urandom());
            endcase
        end
        send_item(cdq_pkg::FUNC_PUSH_FRONT, 32'hDEAD_BEEF);
        send_item(cdq_pkg::FUNC_PUSH_REAR, 32'h0BAD_F00D);
        send_item(cdq_pkg::FUNC_POP_REAR, $urandom());
        send_item(cdq_pkg::FUNC_POP_FRONT, $urandom());
    endtask

    // Random traffic in segments biased toward filling, toward draining, or
    // balanced, so the ring keeps crossing both its empty and full states.
    task automatic test_random_traffic(input int n_items);
        int sent;
        int seg_len;
        int push_pct;
        sent = 0;
        while (sent < n_items)
        begin
            seg_len = $urandom_range(40, 4);
            case ($urandom_range(2))
                0: push_pct = 85;
                1: push_pct = 15;
                default: push_pct = 50;
            endcase
            for (int i = 0; i < seg_len && sent < n_items; i++)
            begin
                // Mix in a few beats with a uniformly random operation code.
                if ($urandom_range(9) == 0)
                    send_item(cdq_pkg::func_t'($urandom_range(3)), $urandom());
                else
                    send_item(pick_op(push_pct), pick_word());
                sent++;
            end
        end
    endtask

    // Hold the output off for a long stretch while the sender offers beats
    // without gaps, so the block backs up and raises item_stall.
    task automatic test_output_hold();
        int saved_idle;
        saved_idle    = send_idle_pct;
        send_idle_pct = 0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (80) @(posedge clk);
                rx_hold <= 1'b0;
            end
        join_none
        for (int i = 0; i < 60; i++)
            send_item(pick_op(60), pick_word());
        send_idle_pct = saved_idle;
    endtask

    // Run-time limit, far above the slowest legal run.
    initial
    begin
        #(CLK_PERIOD * LIMIT_TICKS);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        repeat (RESET_TICKS) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 35;
        recv_idle_pct = 69;
        test_directed();
        test_random_traffic(330);

        send_idle_pct = 69;
        recv_idle_pct = 35;
        test_output_hold();
        test_random_traffic(330);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(300);

        // Drop valid, drain every outstanding result, then let the pipe settle.
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_TICKS) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
